// File: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define LSU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lsu assertion failed");
// consequence that must hold in the cycle after the antecedent
`define LSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsu assertion failed");
`else
`define LSU_ASSERT(lbl, clk, rst_n, prop)
`define LSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/lsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lsu_pkg;
    // store buffer entries
    localparam int BUFFER_DEPTH = 32;
    // main memory size in bytes, a power of two
    localparam int MEMORY_BYTES = 65536;
    // number of reorder buffer tags
    localparam int TAG_COUNT    = 32;

    localparam int BUF_IW  = $clog2(BUFFER_DEPTH);
    localparam int BUF_CW  = $clog2(BUFFER_DEPTH + 1);
    localparam int MEM_AW  = $clog2(MEMORY_BYTES);
    localparam int TAG_W   = 5;
    localparam int DATA_W  = 32;
    localparam int OFF_W   = 12;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_EXEC    = 2'd0,
        CMD_COMMIT  = 2'd1,
        CMD_FLUSH   = 2'd2,
        CMD_PRELOAD = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_LB  = 3'd0,
        KIND_LBU = 3'd1,
        KIND_LH  = 3'd2,
        KIND_LHU = 3'd3,
        KIND_LW  = 3'd4,
        KIND_SB  = 3'd5,
        KIND_SH  = 3'd6,
        KIND_SW  = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LD_REQ,
        S_LD_CAP,
        S_ST_CHK,
        S_ST_WR,
        S_COMMIT,
        S_RESULT
    } t_state;

    // one classified operation as it travels from front to back
    typedef struct packed {
        t_cmd              cmd;
        t_kind             kind;
        logic [MEM_AW-1:0] idx;
        logic [DATA_W-1:0] data;
        logic [TAG_W-1:0]  tag;
    } t_op;
endpackage
`default_nettype wire

// File: hw/rtl/lsu_front.sv
`timescale 1ns / 1ps
`default_nettype none
module lsu_front (
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_command,
    input  logic [2:0]                     i_access_kind,
    input  logic [lsu_pkg::DATA_W-1:0]     i_base_value,
    input  logic signed [lsu_pkg::OFF_W-1:0] i_offset,
    input  logic [lsu_pkg::DATA_W-1:0]     i_store_value,
    input  logic [lsu_pkg::TAG_W-1:0]      i_rob_tag,
    input  logic                           i_full,
    input  logic                           i_clearing,
    output logic                           o_push,
    output lsu_pkg::t_op                   o_op
);
    import lsu_pkg::*;

    // tag reduced into the tag range by repeated subtraction
    function automatic logic [TAG_W-1:0] tag_reduce(input logic [TAG_W-1:0] t);
        logic [TAG_W:0] v;
        v = {1'b0, t};
        for (int s = 0; s < 8; s++) begin
            if (v >= (TAG_W+1)'(TAG_COUNT)) begin
                v = v - (TAG_W+1)'(TAG_COUNT);
            end
        end
        return v[TAG_W-1:0];
    endfunction

    logic [DATA_W-1:0] addr;
    t_cmd              cmd;

    assign cmd  = t_cmd'(i_command);
    assign addr = i_base_value + DATA_W'(i_offset);

    assign o_ready = !i_full && !i_clearing;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_op.cmd  = cmd;
        o_op.kind = t_kind'(i_access_kind);
        o_op.data = i_store_value;
        o_op.tag  = tag_reduce(i_rob_tag);
        // preload takes the base as its byte address
        if (cmd == CMD_PRELOAD) begin
            o_op.idx = i_base_value[MEM_AW-1:0];
        end else begin
            o_op.idx = addr[MEM_AW-1:0];
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/lsu_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module lsu_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  lsu_pkg::t_op i_op,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_nonempty,
    output lsu_pkg::t_op o_op
);
    import lsu_pkg::*;

    t_op                r_buf [FIFO_DEPTH];
    logic [FIFO_PW-1:0] r_wr_ptr;
    logic [FIFO_PW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;

    assign o_full     = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_op       = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_op;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/lsu_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lsu_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_op_valid,
    input  lsu_pkg::t_op               i_op,
    output logic                       o_pop,
    output logic                       o_clearing,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [lsu_pkg::TAG_W-1:0]  o_result_tag,
    output logic [lsu_pkg::DATA_W-1:0] o_load_data,
    output logic                       o_status
);
    import lsu_pkg::*;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [1:0]        r_k, n_k, r_last, n_last;
    logic [2:0]        r_need, n_need;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic              r_status, n_status;
    logic              r_hit, n_hit;
    logic [7:0]        r_hit_byte, n_hit_byte;
    logic [BUF_CW-1:0] r_used, n_used;
    logic [MEM_AW-1:0] r_clr_addr, n_clr_addr;

    logic [BUFFER_DEPTH-1:0] r_valid;
    logic [MEM_AW-1:0]       r_baddr [BUFFER_DEPTH];
    logic [7:0]              r_bbyte [BUFFER_DEPTH];
    logic [TAG_W-1:0]        r_bown  [BUFFER_DEPTH];

    logic [7:0]        r_mem [MEMORY_BYTES];
    logic [7:0]        r_rdata;

    logic              r_out_valid;
    logic [TAG_W-1:0]  r_out_tag;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_status;

    logic [MEM_AW-1:0]       cur_idx;
    logic [BUFFER_DEPTH-1:0] hit_vec, com_vec;
    logic                    hit_any, com_any;
    logic [BUF_IW-1:0]       hit_sel, com_sel, free_sel, buf_ridx, buf_widx;
    logic [BUF_CW-1:0]       free_cnt;
    logic [2:0]              need_fin;
    logic [7:0]              st_byte;
    logic                    out_free, out_load;
    logic [DATA_W-1:0]       res_data;
    logic                    mem_we;
    logic [MEM_AW-1:0]       mem_waddr;
    logic [7:0]              mem_wdata;
    logic                    buf_we, buf_alloc, buf_clr, buf_flush;

    assign cur_idx = r_op.idx + MEM_AW'(r_k);

    always_comb begin
        for (int i = 0; i < BUFFER_DEPTH; i++) begin
            hit_vec[i] = r_valid[i] && (r_baddr[i] == cur_idx);
            com_vec[i] = r_valid[i] && (r_bown[i] == r_op.tag);
        end
    end

    assign hit_any = |hit_vec;
    assign com_any = |com_vec;

    // lowest index first for every encoder
    always_comb begin
        hit_sel  = '0;
        com_sel  = '0;
        free_sel = '0;
        for (int i = BUFFER_DEPTH - 1; i >= 0; i--) begin
            if (hit_vec[i]) hit_sel = BUF_IW'(i);
            if (com_vec[i]) com_sel = BUF_IW'(i);
            if (!r_valid[i]) free_sel = BUF_IW'(i);
        end
    end

    assign buf_ridx = (r_state == S_COMMIT) ? com_sel : hit_sel;
    assign buf_widx = hit_any ? hit_sel : free_sel;
    assign free_cnt = BUF_CW'(BUFFER_DEPTH) - r_used;
    assign need_fin = r_need + {2'b00, !hit_any};
    assign st_byte  = r_op.data[{r_k, 3'b000} +: 8];
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        case (r_op.kind)
            KIND_LB: res_data = {{(DATA_W-8){r_acc[7]}}, r_acc[7:0]};
            KIND_LH: res_data = {{(DATA_W-16){r_acc[15]}}, r_acc[15:0]};
            default: res_data = r_acc;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == MEM_AW'(MEMORY_BYTES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_op_valid) begin
                    case (i_op.cmd)
                        CMD_EXEC: begin
                            if (i_op.kind == KIND_SB || i_op.kind == KIND_SH
                                    || i_op.kind == KIND_SW) begin
                                n_state = S_ST_CHK;
                            end else begin
                                n_state = S_LD_REQ;
                            end
                        end
                        CMD_COMMIT: n_state = S_COMMIT;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_LD_REQ: n_state = S_LD_CAP;
            S_LD_CAP: begin
                if (r_k == r_last) n_state = S_RESULT;
                else n_state = S_LD_REQ;
            end
            S_ST_CHK: begin
                if (r_k == r_last) begin
                    if (BUF_CW'(need_fin) > free_cnt) n_state = S_RESULT;
                    else n_state = S_ST_WR;
                end
            end
            S_ST_WR: begin
                if (r_k == r_last) n_state = S_RESULT;
            end
            S_COMMIT: begin
                if (!com_any) n_state = S_IDLE;
            end
            S_RESULT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        n_op       = r_op;
        n_k        = r_k;
        n_last     = r_last;
        n_need     = r_need;
        n_acc      = r_acc;
        n_status   = r_status;
        n_hit      = r_hit;
        n_hit_byte = r_hit_byte;
        n_used     = r_used;
        n_clr_addr = r_clr_addr;
        o_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = i_op.idx;
        mem_wdata  = i_op.data[7:0];
        buf_we     = 1'b0;
        buf_alloc  = 1'b0;
        buf_clr    = 1'b0;
        buf_flush  = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
            end
            S_IDLE: begin
                o_pop = i_op_valid;
                if (i_op_valid) begin
                    n_op     = i_op;
                    n_k      = '0;
                    n_need   = '0;
                    n_acc    = '0;
                    n_status = 1'b0;
                    case (i_op.kind)
                        KIND_LB, KIND_LBU, KIND_SB: n_last = 2'd0;
                        KIND_LH, KIND_LHU, KIND_SH: n_last = 2'd1;
                        default:                    n_last = 2'd3;
                    endcase
                    case (i_op.cmd)
                        CMD_FLUSH: begin
                            buf_flush = 1'b1;
                            n_used    = '0;
                        end
                        CMD_PRELOAD: mem_we = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_LD_REQ: begin
                n_hit      = hit_any;
                n_hit_byte = r_bbyte[buf_ridx];
            end
            S_LD_CAP: begin
                n_acc[{r_k, 3'b000} +: 8] = r_hit ? r_hit_byte : r_rdata;
                n_k = r_k + 1'b1;
            end
            S_ST_CHK: begin
                n_need = need_fin;
                if (r_k == r_last) begin
                    n_k = '0;
                    if (BUF_CW'(need_fin) > free_cnt) n_status = 1'b1;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_ST_WR: begin
                buf_we = 1'b1;
                if (!hit_any) begin
                    buf_alloc = 1'b1;
                    n_used    = r_used + 1'b1;
                end
                n_k = r_k + 1'b1;
            end
            S_COMMIT: begin
                if (com_any) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_baddr[com_sel];
                    mem_wdata = r_bbyte[buf_ridx];
                    buf_clr   = 1'b1;
                    n_used    = r_used - 1'b1;
                end
            end
            S_RESULT: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_used      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_used     <= n_used;
            if (buf_flush) begin
                r_valid <= '0;
            end else if (buf_alloc) begin
                r_valid[free_sel] <= 1'b1;
            end else if (buf_clr) begin
                r_valid[com_sel] <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_k        <= n_k;
        r_last     <= n_last;
        r_need     <= n_need;
        r_acc      <= n_acc;
        r_status   <= n_status;
        r_hit      <= n_hit;
        r_hit_byte <= n_hit_byte;
        if (buf_we) begin
            r_bbyte[buf_widx] <= st_byte;
            r_bown[buf_widx]  <= r_op.tag;
        end
        if (buf_alloc) begin
            r_baddr[buf_widx] <= cur_idx;
        end
        if (out_load) begin
            r_out_tag    <= r_op.tag;
            r_out_data   <= res_data;
            r_out_status <= r_status;
        end
    end

    // byte memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[cur_idx];
    end

    assign o_clearing   = (r_state == S_CLEAR);
    assign o_valid      = r_out_valid;
    assign o_result_tag = r_out_tag;
    assign o_load_data  = r_out_data;
    assign o_status     = r_out_status;

    `LSU_ASSERT(a_used_bound, i_clk, i_rst_n, r_used <= BUF_CW'(BUFFER_DEPTH))
    `LSU_ASSERT(a_used_matches, i_clk, i_rst_n, $countones(r_valid) == 32'(r_used))
    `LSU_ASSERT(a_hit_unique, i_clk, i_rst_n, $onehot0(hit_vec))
    `LSU_ASSERT_NEXT(a_flush_empties, i_clk, i_rst_n, buf_flush, r_valid == '0)
endmodule
`default_nettype wire

// File: hw/rtl/load_store_unit_with_store_buffer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// load/store unit with a speculative store buffer. a word on the input channel carries one
// command: execute a byte, halfword or word load or store at base plus signed offset
// (little-endian), commit every buffered byte of a tag to memory, flush the buffer, or
// preload one memory byte. only execute returns a result word: the tag, the extended load
// value (zero for stores) and a status bit that is set when a store did not fit in the
// buffer and was dropped. stores land in the buffer, one entry per byte, and a later store
// to a buffered byte takes over that entry. loads read each byte from the buffer when it
// holds the address, else from memory. the front end accepts and classifies words into a
// two-entry queue; the back end runs them one at a time on a byte memory with one write
// port and one registered read port. loads and stores step through their bytes one at a
// time, a store checking room for all its bytes before it writes any; a commit drains the
// bytes of its tag one at a time. after reset the memory is zeroed, and no input word is
// accepted until that pass is done.
module load_store_unit_with_store_buffer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_command,
    input  logic [2:0]                        i_access_kind,
    input  logic [lsu_pkg::DATA_W-1:0]        i_base_value,
    input  logic signed [lsu_pkg::OFF_W-1:0]  i_offset,
    input  logic [lsu_pkg::DATA_W-1:0]        i_store_value,
    input  logic [lsu_pkg::TAG_W-1:0]         i_rob_tag,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [lsu_pkg::TAG_W-1:0]         o_result_tag,
    output logic [lsu_pkg::DATA_W-1:0]        o_load_data,
    output logic                              o_status
);
    import lsu_pkg::*;

    // classified operation from the front end into the queue
    t_op  push_op;
    logic push;
    // queue head toward the back end
    t_op  head_op;
    logic head_valid;
    logic pop;
    logic q_full;
    logic clearing;

    lsu_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_access_kind (i_access_kind),
        .i_base_value  (i_base_value),
        .i_offset      (i_offset),
        .i_store_value (i_store_value),
        .i_rob_tag     (i_rob_tag),
        .i_full        (q_full),
        .i_clearing    (clearing),
        .o_push        (push),
        .o_op          (push_op)
    );

    // short queue so front and back stall independently
    lsu_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_op       (push_op),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (head_valid),
        .o_op       (head_op)
    );

    // sequencer, store buffer, byte memory and result register
    lsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_valid   (head_valid),
        .i_op         (head_op),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result_tag (o_result_tag),
        .o_load_data  (o_load_data),
        .o_status     (o_status)
    );
endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import lsu_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 60;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #6 i_clk = ~i_clk;

    // input channel
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_command = CMD_FLUSH;
    logic [2:0]  i_access_kind = KIND_LB;
    logic [31:0] i_base_value = '0;
    logic signed [11:0] i_offset = '0;
    logic [31:0] i_store_value = '0;
    logic [4:0]  i_rob_tag = '0;

    // result channel
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [4:0]  o_result_tag;
    logic [31:0] o_load_data;
    logic        o_status;

    load_store_unit_with_store_buffer_top uut (.*);

    // expected result word
    typedef struct packed {
        logic [4:0]  tag;
        logic [31:0] data;
        logic        status;
    } t_result;

    t_result expected_results[$];

    // predictor state: store buffer and byte memory
    logic        sb_valid [BUFFER_DEPTH];
    logic [15:0] sb_addr  [BUFFER_DEPTH];
    logic [7:0]  sb_byte  [BUFFER_DEPTH];
    logic [4:0]  sb_owner [BUFFER_DEPTH];
    logic [7:0]  mem_image [MEMORY_BYTES];

    int error_count   = 0;
    int words_sent    = 0;
    int results_seen  = 0;
    int full_drops    = 0;
    int idle_cycles   = 0;
    bit stall_results = 1'b0;  // forces a long receiver hold-off
    bit gaps_enabled  = 1'b1;

    function automatic int find_slot(logic [15:0] a);
        for (int i = 0; i < BUFFER_DEPTH; i++)
            if (sb_valid[i] && sb_addr[i] == a) return i;
        return -1;
    endfunction

    function automatic logic [7:0] image_byte(logic [31:0] a);
        int e;
        e = find_slot(a[15:0]);
        if (e >= 0) return sb_byte[e];
        return mem_image[a[15:0]];
    endfunction

    // buffers n bytes, all or nothing; returns 1 when dropped
    function automatic bit buffer_store(logic [31:0] a, logic [31:0] v, int n,
                                        logic [4:0] tag);
        int need;
        int free_cnt;
        int e;
        logic [31:0] b;
        need = 0;
        free_cnt = 0;
        for (int k = 0; k < n; k++) begin
            b = a + k;
            if (find_slot(b[15:0]) < 0) need++;
        end
        for (int i = 0; i < BUFFER_DEPTH; i++)
            if (!sb_valid[i]) free_cnt++;
        if (need > free_cnt) return 1'b1;
        for (int k = 0; k < n; k++) begin
            b = a + k;
            e = find_slot(b[15:0]);
            if (e < 0) begin
                for (e = 0; e < BUFFER_DEPTH; e++)
                    if (!sb_valid[e]) break;
                sb_valid[e] = 1'b1;
                sb_addr[e]  = b[15:0];
            end
            sb_byte[e]  = v[8*k +: 8];
            sb_owner[e] = tag;
        end
        return 1'b0;
    endfunction

    // applies one accepted word to the predictor, queues a result for execute
    task automatic predict_lsu(logic [1:0] cmd, logic [2:0] kind, logic [31:0] base,
                               logic [11:0] off, logic [31:0] sval, logic [4:0] tag);
        logic [31:0] a;
        logic [7:0]  b0;
        t_result r;
        case (cmd)
            CMD_COMMIT: begin
                for (int i = 0; i < BUFFER_DEPTH; i++)
                    if (sb_valid[i] && sb_owner[i] == tag) begin
                        mem_image[sb_addr[i]] = sb_byte[i];
                        sb_valid[i] = 1'b0;
                    end
            end
            CMD_FLUSH: for (int i = 0; i < BUFFER_DEPTH; i++) sb_valid[i] = 1'b0;
            CMD_PRELOAD: mem_image[base[15:0]] = sval[7:0];
            default: begin
                a = base + {{20{off[11]}}, off};
                r.tag = tag;
                r.data = '0;
                r.status = 1'b0;
                case (kind)
                    KIND_LB: begin
                        b0 = image_byte(a);
                        r.data = {{24{b0[7]}}, b0};
                    end
                    KIND_LBU: r.data = {24'd0, image_byte(a)};
                    KIND_LH, KIND_LHU: begin
                        r.data = {16'd0, image_byte(a + 1), image_byte(a)};
                        if (kind == KIND_LH && r.data[15]) r.data[31:16] = 16'hFFFF;
                    end
                    KIND_LW: r.data = {image_byte(a + 3), image_byte(a + 2),
                                       image_byte(a + 1), image_byte(a)};
                    KIND_SB: r.status = buffer_store(a, sval, 1, tag);
                    KIND_SH: r.status = buffer_store(a, sval, 2, tag);
                    default: r.status = buffer_store(a, sval, 4, tag);
                endcase
                if (r.status) full_drops++;
                expected_results.push_back(r);
            end
        endcase
    endtask

    // mostly short gaps, now and then a long one
    function automatic int random_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // drives one word and waits for its acceptance
    task automatic send_word(logic [1:0] cmd, logic [2:0] kind, logic [31:0] base,
                             logic [11:0] off, logic [31:0] sval, logic [4:0] tag);
        int gap;
        gap = gaps_enabled ? random_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_access_kind <= kind;
        i_base_value  <= base;
        i_offset      <= off;
        i_store_value <= sval;
        i_rob_tag     <= tag;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_lsu(cmd, kind, base, off, sval, tag);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic release_input();
        i_valid <= 1'b0;
    endtask

    task automatic wait_results_done();
        release_input();
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // receiver side: random ready, with optional forced hold-off
    always @(negedge i_clk) begin
        if (stall_results) i_ready <= 1'b0;
        else if (!gaps_enabled) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 99) < 8) ? 1'b0 : (random_gap() == 0);
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result word tag", o_result_tag, '0);
            end else begin
                want = expected_results.pop_front();
                if (o_result_tag !== want.tag) report_mismatch("tag", o_result_tag, want.tag);
                if (o_load_data !== want.data) report_mismatch("data", o_load_data, want.data);
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
            end
        end
    end

    // watchdog: cycles with no handshake on either side, after the clearing pass
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT + MEMORY_BYTES) begin
            $display("watchdog expired, no progress");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // small address window so loads hit buffered and preloaded bytes
    function automatic logic [31:0] near_addr();
        return {$urandom_range(0, 3) == 0 ? $urandom() : 32'd0} & 32'hFFFF_0000
               | $urandom_range(16'h100, 16'h13F);
    endfunction

    task automatic test_directed();
        // extreme offsets, address wrap, sign extension on every load kind
        send_word(CMD_PRELOAD, KIND_LB, 32'h0000_0000, 12'h000, 32'hFFFF_FF80, 5'd0);
        send_word(CMD_PRELOAD, KIND_LB, 32'h0000_0001, 12'h000, 32'h0000_00FF, 5'd0);
        send_word(CMD_PRELOAD, KIND_LB, 32'h0000_FFFF, 12'h000, 32'h0000_007F, 5'd0);
        for (int k = KIND_LB; k <= KIND_LW; k++)
            send_word(CMD_EXEC, k[2:0], 32'h0000_0000, 12'h000, 32'h0, 5'd31);
        send_word(CMD_EXEC, KIND_LW, 32'hFFFF_FFFF, 12'h000, 32'h0, 5'd1);
        send_word(CMD_EXEC, KIND_LH, 32'h0000_0800, 12'h800, 32'h0, 5'd2);
        send_word(CMD_EXEC, KIND_LBU, 32'h0000_0000, 12'h7FF, 32'h0, 5'd3);
        // stores, overlap replacing owner, aliasing through the memory size
        send_word(CMD_EXEC, KIND_SW, 32'h0000_FFFE, 12'h000, 32'hDEAD_BEEF, 5'd4);
        send_word(CMD_EXEC, KIND_SB, 32'h0001_FFFF, 12'h000, 32'hFFFF_FF11, 5'd5);
        send_word(CMD_EXEC, KIND_SH, 32'h0000_0001, 12'hFFF, 32'h1234_5678, 5'd6);
        send_word(CMD_EXEC, KIND_LW, 32'hFFFF_FFFE, 12'h000, 32'h0, 5'd7);
        send_word(CMD_COMMIT, KIND_LB, 32'h0, 12'h0, 32'h0, 5'd9);
        send_word(CMD_COMMIT, KIND_LB, 32'h0, 12'h0, 32'h0, 5'd4);
        send_word(CMD_PRELOAD, KIND_LB, 32'h0000_FFFF, 12'h0, 32'h0000_00AA, 5'd0);
        send_word(CMD_EXEC, KIND_LW, 32'h0000_FFFE, 12'h000, 32'h0, 5'd8);
        send_word(CMD_FLUSH, KIND_LB, 32'h0, 12'h0, 32'h0, 5'd0);
        send_word(CMD_EXEC, KIND_LW, 32'h0000_FFFE, 12'h000, 32'h0, 5'd10);
        wait_results_done();
    endtask

    task automatic test_buffer_full();
        // eight words fill the buffer, then a new address must be dropped
        for (int i = 0; i < 8; i++)
            send_word(CMD_EXEC, KIND_SW, 32'h200 + 4 * i, 12'h0, $urandom(), i[4:0]);
        send_word(CMD_EXEC, KIND_SB, 32'h300, 12'h0, 32'h55, 5'd20);
        send_word(CMD_EXEC, KIND_SH, 32'h200, 12'h0, 32'hABCD, 5'd21);
        send_word(CMD_EXEC, KIND_LW, 32'h200, 12'h0, 32'h0, 5'd22);
        send_word(CMD_COMMIT, KIND_LB, 32'h0, 12'h0, 32'h0, 5'd21);
        send_word(CMD_EXEC, KIND_SW, 32'h300, 12'h0, 32'h5555_AAAA, 5'd23);
        wait_results_done();
        send_word(CMD_FLUSH, KIND_LB, 32'h0, 12'h0, 32'h0, 5'd0);
    endtask

    task automatic test_backpressure();
        // receiver holds off while words keep coming, so the unit stalls its input
        fork
            begin
                stall_results = 1'b1;
                repeat (150) @(negedge i_clk);
                stall_results = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                send_word(CMD_EXEC, $urandom_range(KIND_LB, KIND_SW), near_addr(),
                          $urandom(), $urandom(), $urandom());
        join
        wait_results_done();
    endtask

    task automatic test_random(int count);
        int p;
        for (int i = 0; i < count; i++) begin
            p = $urandom_range(0, 99);
            if (i == count / 2) begin
                // one stretch with no idling on either side
                gaps_enabled = ~gaps_enabled;
            end
            if (p < 70)
                send_word(CMD_EXEC, $urandom_range(KIND_LB, KIND_SW), near_addr(),
                          $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 15),
                          $urandom(), $urandom_range(0, 7) == 0 ? $urandom() :
                          $urandom_range(0, 3));
            else if (p < 75)
                send_word(CMD_EXEC, $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom());
            else if (p < 87)
                send_word(CMD_COMMIT, $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 3));
            else if (p < 90)
                send_word(CMD_FLUSH, $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom());
            else
                send_word(CMD_PRELOAD, $urandom(), p < 97 ? near_addr() : $urandom(),
                          $urandom(), $urandom(), $urandom());
        end
        gaps_enabled = 1'b1;
        wait_results_done();
    endtask

    initial begin
        for (int i = 0; i < BUFFER_DEPTH; i++) sb_valid[i] = 1'b0;
        for (int i = 0; i < MEMORY_BYTES; i++) mem_image[i] = 8'd0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_buffer_full();
        test_backpressure();
        test_random(600);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("sent %0d words, checked %0d results, %0d stores dropped on full buffer",
                 words_sent, results_seen, full_drops);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d errors, %0d results missing", error_count,
                     expected_results.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
